// File: rtl/ptrf_pkg.sv
// Package for the printable text run finder.
// Holds the beat types, encoding codes, counter width and the printable test.
// No dependencies.
package ptrf_pkg;

    localparam int LEN_W      = 16;
    localparam int ADDR_W     = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_W-1:0] COUNT_MAX   = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] MIN_RST     = LEN_W'(4);
    localparam logic [7:0]       PRINT_LO    = 8'h20;
    localparam logic [7:0]       PRINT_HI    = 8'h7E;

    localparam logic [1:0] ENC_ASCII = 2'd0;
    localparam logic [1:0] ENC_WIDE  = 2'd1;
    localparam logic [1:0] ENC_NONE  = 2'd2;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        encoding;
        logic [ADDR_W-1:0] run_address;
        logic [LEN_W-1:0]  run_length;
        logic              final_result;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_beat  first;
        t_out_beat  second;
    } t_push_bus;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

endpackage

// File: rtl/printable_text_run_finder_top.sv
// Top level of the printable text run finder.
// Input register, scanner core, result queue and min_run_length register.
// Depends on ptrf_pkg, ptrf_scan, ptrf_outq.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte beat
//   with its address and a last_byte flag that closes the snapshot.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries run
//   descriptors: ASCII, UTF-16LE, or one "none" beat when the snapshot held
//   no run. final_result marks the last descriptor of a snapshot's last byte.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   min_run_length; it is always ready. Write it only while the block is idle.
// Timing:
//   A byte accepted into the input register is scanned there; its descriptors
//   are written into the result queue when the scanner advances, which needs
//   room for two beats, and the output channel then takes them from the queue.
//   Throughput is one byte per cycle while the queue has room for two beats;
//   each byte may queue up to two descriptors and the output drains one per
//   cycle, so the four-entry result queue sets the rate for faster arrivals.
// Reset and stall:
//   Reset clears all scan state and the queue and sets min_run_length to 4.
//   When the receiver stalls, the queue fills and then o_in_ready drops after
//   the input register holds a byte; nothing is lost.
module printable_text_run_finder_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ptrf_pkg::t_in_beat        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ptrf_pkg::t_out_beat       o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ptrf_pkg::LEN_W-1:0] i_cfg_data
);

    logic                        r_in_valid;
    ptrf_pkg::t_in_beat          r_in;
    logic [ptrf_pkg::LEN_W-1:0]  r_min_len;
    logic                        space;
    logic                        adv;
    ptrf_pkg::t_push_bus         push;

    assign adv         = r_in_valid && space;
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= ptrf_pkg::MIN_RST;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    ptrf_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_beat    (r_in),
        .i_min_len (r_min_len),
        .o_push    (push)
    );

    ptrf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// File: rtl/ptrf_scan.sv
// Scanner core of the printable text run finder: ASCII and UTF-16LE run state.
// Takes one registered input beat per advance and emits up to two descriptors.
// Depends on ptrf_pkg.
module ptrf_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  ptrf_pkg::t_in_beat   i_beat,
    input  logic [ptrf_pkg::LEN_W-1:0] i_min_len,
    output ptrf_pkg::t_push_bus  o_push
);

    logic [ptrf_pkg::LEN_W-1:0]  r_ascii_count, n_ascii_count;
    logic [ptrf_pkg::ADDR_W-1:0] r_ascii_start, n_ascii_start;
    logic [ptrf_pkg::LEN_W-1:0]  r_wide_count, n_wide_count;
    logic [ptrf_pkg::ADDR_W-1:0] r_wide_start, n_wide_start;
    logic [7:0]                  r_held_byte, n_held_byte;
    logic [ptrf_pkg::ADDR_W-1:0] r_held_address, n_held_address;
    logic                        r_held_valid, n_held_valid;
    logic                        r_found_any, n_found_any;

    logic [ptrf_pkg::LEN_W-1:0]  minlen;
    logic [ptrf_pkg::LEN_W-1:0]  a_cnt, w_cnt;
    logic [ptrf_pkg::ADDR_W-1:0] a_start, w_start;
    logic                        a_end, w_end, a_hit, w_hit, none_hit, last;
    ptrf_pkg::t_out_beat         a_beat, w_beat, none_beat;
    logic [1:0]                  res_cnt;

    always_comb begin
        last           = i_beat.last_byte;
        minlen         = (i_min_len == '0) ? ptrf_pkg::LEN_W'(1) : i_min_len;
        a_cnt          = r_ascii_count;
        a_start        = r_ascii_start;
        w_cnt          = r_wide_count;
        w_start        = r_wide_start;
        n_held_byte    = r_held_byte;
        n_held_address = r_held_address;
        n_held_valid   = r_held_valid;
        a_end          = 1'b0;
        w_end          = 1'b0;

        if (ptrf_pkg::is_printable(i_beat.data_byte)) begin
            if (r_ascii_count == '0) begin
                a_start = i_beat.byte_address;
            end
            if (r_ascii_count != ptrf_pkg::COUNT_MAX) begin
                a_cnt = r_ascii_count + 1'b1;
            end
        end else begin
            a_end = 1'b1;
        end

        if (r_held_valid && ptrf_pkg::is_printable(r_held_byte)
                && (i_beat.data_byte == 8'h00)) begin
            if (r_wide_count == '0) begin
                w_start = r_held_address;
            end
            if (r_wide_count != ptrf_pkg::COUNT_MAX) begin
                w_cnt = r_wide_count + 1'b1;
            end
            n_held_valid = 1'b0;
        end else begin
            w_end          = r_held_valid;
            n_held_byte    = i_beat.data_byte;
            n_held_address = i_beat.byte_address;
            n_held_valid   = 1'b1;
        end

        if (last) begin
            a_end = 1'b1;
            w_end = 1'b1;
        end

        a_hit       = a_end && (a_cnt >= minlen);
        w_hit       = w_end && (w_cnt >= minlen);
        n_found_any = r_found_any | a_hit | w_hit;
        none_hit    = last && !n_found_any;
        res_cnt     = 2'(a_hit) + 2'(w_hit) + 2'(none_hit);

        n_ascii_count = a_end ? '0 : a_cnt;
        n_ascii_start = a_start;
        n_wide_count  = w_end ? '0 : w_cnt;
        n_wide_start  = w_start;

        if (last) begin
            n_ascii_start  = '0;
            n_wide_start   = '0;
            n_held_byte    = '0;
            n_held_address = '0;
            n_held_valid   = 1'b0;
            n_found_any    = 1'b0;
        end

        a_beat    = '{encoding: ptrf_pkg::ENC_ASCII, run_address: a_start,
                      run_length: a_cnt, final_result: 1'b0};
        w_beat    = '{encoding: ptrf_pkg::ENC_WIDE, run_address: w_start,
                      run_length: w_cnt, final_result: 1'b0};
        none_beat = '{encoding: ptrf_pkg::ENC_NONE, run_address: '0,
                      run_length: '0, final_result: 1'b0};

        o_push.cnt    = i_adv ? res_cnt : 2'd0;
        o_push.first  = a_hit ? a_beat : (w_hit ? w_beat : none_beat);
        o_push.second = w_beat;
        o_push.first.final_result  = last && (res_cnt == 2'd1);
        o_push.second.final_result = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_count  <= '0;
            r_ascii_start  <= '0;
            r_wide_count   <= '0;
            r_wide_start   <= '0;
            r_held_byte    <= '0;
            r_held_address <= '0;
            r_held_valid   <= 1'b0;
            r_found_any    <= 1'b0;
        end else if (i_adv) begin
            r_ascii_count  <= n_ascii_count;
            r_ascii_start  <= n_ascii_start;
            r_wide_count   <= n_wide_count;
            r_wide_start   <= n_wide_start;
            r_held_byte    <= n_held_byte;
            r_held_address <= n_held_address;
            r_held_valid   <= n_held_valid;
            r_found_any    <= n_found_any;
        end
    end

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_beat.last_byte |=> (r_ascii_count == '0) && (r_wide_count == '0)
            && !r_held_valid && !r_found_any)
        else $error("scan state not cleared after final beat");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_beat.last_byte && !r_found_any |-> o_push.cnt != 2'd0)
        else $error("final beat of empty snapshot gave no descriptor");

    a_found_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_beat.last_byte && (o_push.cnt != 2'd0) |=> r_found_any)
        else $error("found flag not set after a descriptor");

endmodule

// File: rtl/ptrf_outq.sv
// Result queue of the printable text run finder: takes up to two beats a cycle,
// hands one beat a cycle out while i_ready is high. Depends on ptrf_pkg.
module ptrf_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptrf_pkg::t_push_bus  i_push,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ptrf_pkg::t_out_beat  o_data
);

    ptrf_pkg::t_out_beat r_mem [ptrf_pkg::FIFO_DEPTH];
    logic [ptrf_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ptrf_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ptrf_pkg::FIFO_CNT_W-1:0] r_count, n_count;
    logic [ptrf_pkg::FIFO_PTR_W-1:0] wr_next;
    logic                            pop;

    always_comb begin
        pop      = o_valid && i_ready;
        wr_next  = r_wr_ptr + 1'b1;
        n_wr_ptr = r_wr_ptr + ptrf_pkg::FIFO_PTR_W'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + ptrf_pkg::FIFO_PTR_W'(pop);
        n_count  = r_count + ptrf_pkg::FIFO_CNT_W'(i_push.cnt)
                 - ptrf_pkg::FIFO_CNT_W'(pop);
    end

    assign o_space = r_count <= ptrf_pkg::FIFO_CNT_W'(ptrf_pkg::FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptrf_pkg::FIFO_CNT_W'(ptrf_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space)
        else $error("push without room for two beats");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != ptrf_pkg::FIFO_CNT_W'(ptrf_pkg::FIFO_DEPTH))
            |-> (ptrf_pkg::FIFO_PTR_W'(r_wr_ptr - r_rd_ptr)
                 == ptrf_pkg::FIFO_PTR_W'(r_count)))
        else $error("queue pointers disagree with fill count");

endmodule
